/* hw/rtl/rcpwd_pkg.sv */
// Shared types and constants of the RC pulse width decoder.
package rcpwd_pkg;

  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 16;

  localparam logic [CfgIdxBits-1:0] CFG_MEDIAN   = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_DEADZONE = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_GAP_LIM  = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_GAIN_POS = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_GAIN_NEG = 3'd4;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [11:0] MEDIAN_RST   = 12'd1500;
  localparam logic [9:0]  DEADZONE_RST = 10'd20;
  localparam logic [15:0] GAP_LIM_RST  = 16'd3000;
  localparam logic [15:0] GAIN_RST     = 16'd131;

  // Reads outside the deadzone needed before the position is let through
  localparam logic [1:0] CONFIRM_DONE = 2'd3;

  typedef struct packed {
    logic [11:0] median_us;
    logic [9:0]  deadzone_us;
    logic [15:0] gap_limit_us;
    logic [15:0] gain_pos;
    logic [15:0] gain_neg;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] product;
  } prod_t;

endpackage

/* hw/rtl/rcpwd_cfg_regs.sv */
// Configuration register file of the RC pulse width decoder.
module rcpwd_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rcpwd_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [rcpwd_pkg::CfgDataBits-1:0] cfg_data,
  output rcpwd_pkg::cfg_t                   cfg
);

  rcpwd_pkg::cfg_t cfg_r;
  rcpwd_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        rcpwd_pkg::CFG_MEDIAN:   cfg_nxt.median_us    = cfg_data[11:0];
        rcpwd_pkg::CFG_DEADZONE: cfg_nxt.deadzone_us  = cfg_data[9:0];
        rcpwd_pkg::CFG_GAP_LIM:  cfg_nxt.gap_limit_us = cfg_data;
        rcpwd_pkg::CFG_GAIN_POS: cfg_nxt.gain_pos     = cfg_data;
        rcpwd_pkg::CFG_GAIN_NEG: cfg_nxt.gain_neg     = cfg_data;
        default:                 cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.median_us    <= rcpwd_pkg::MEDIAN_RST;
      cfg_r.deadzone_us  <= rcpwd_pkg::DEADZONE_RST;
      cfg_r.gap_limit_us <= rcpwd_pkg::GAP_LIM_RST;
      cfg_r.gain_pos     <= rcpwd_pkg::GAIN_RST;
      cfg_r.gain_neg     <= rcpwd_pkg::GAIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hw/rtl/rcpwd_core.sv */
// Input register, pulse state and gain multiply stage of the decoder.
module rcpwd_core #(
  parameter int TIMESTAMP_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_operation,
  input  logic [31:0]     in_timestamp_us,
  input  rcpwd_pkg::cfg_t cfg,
  output rcpwd_pkg::prod_t prod,
  input  logic            prod_ready
);

  logic                      s1_valid_r;
  logic                      s1_op_r;
  logic [31:0]               s1_ts_r;
  logic [TIMESTAMP_BITS-1:0] last_edge_r;
  logic [TIMESTAMP_BITS-1:0] last_edge_nxt;
  logic signed [15:0]        offset_r;
  logic signed [15:0]        offset_nxt;
  logic [1:0]                confirm_r;
  logic [1:0]                confirm_nxt;
  rcpwd_pkg::prod_t          prod_r;
  rcpwd_pkg::prod_t          prod_nxt;

  logic                      s2_ready;
  logic                      advance;
  logic [TIMESTAMP_BITS-1:0] ts_cut;
  logic [TIMESTAMP_BITS-1:0] gap;
  logic                      in_limit;
  logic signed [17:0]        diff;
  logic signed [15:0]        offset_new;
  logic signed [16:0]        off_ext;
  logic signed [16:0]        mag;
  logic signed [16:0]        dz_ext;
  logic                      in_dz;
  logic                      confirmed;
  logic signed [16:0]        opnd;
  logic signed [16:0]        gain_ext;
  logic signed [33:0]        product;

  assign s2_ready = !prod_r.valid || prod_ready;
  assign in_ready = !s1_valid_r || s2_ready;
  assign advance  = s1_valid_r && s2_ready;
  assign prod     = prod_r;

  // Edge: width of the gap since the last edge, as offset from centre
  assign ts_cut     = TIMESTAMP_BITS'(s1_ts_r);
  assign gap        = ts_cut - last_edge_r;
  assign in_limit   = gap <= TIMESTAMP_BITS'(cfg.gap_limit_us);
  assign diff       = $signed({2'b00, gap[15:0]}) - $signed({6'd0, cfg.median_us});
  assign offset_new = (diff > 18'sd32767) ? 16'sh7fff : diff[15:0];

  // Read: deadzone test and gain of the matching side
  assign off_ext   = {offset_r[15], offset_r};
  assign mag       = off_ext[16] ? -off_ext : off_ext;
  assign dz_ext    = $signed({7'd0, cfg.deadzone_us});
  assign in_dz     = mag < dz_ext;
  assign confirmed = confirm_r == rcpwd_pkg::CONFIRM_DONE;
  assign opnd      = (off_ext > 17'sd0) ? off_ext - dz_ext : off_ext + dz_ext;
  assign gain_ext  = (off_ext > 17'sd0) ? $signed({1'b0, cfg.gain_pos})
                                        : $signed({1'b0, cfg.gain_neg});
  assign product   = opnd * gain_ext;

  always_comb begin
    last_edge_nxt = last_edge_r;
    offset_nxt    = offset_r;
    confirm_nxt   = confirm_r;
    if (advance) begin
      if (s1_op_r == rcpwd_pkg::OP_EDGE) begin
        last_edge_nxt = ts_cut;
        if (in_limit) begin
          offset_nxt = offset_new;
        end
      end else if (in_dz) begin
        confirm_nxt = 2'd0;
      end else if (!confirmed) begin
        confirm_nxt = confirm_r + 2'd1;
      end
    end
  end

  always_comb begin
    prod_nxt.valid   = s1_valid_r && (s1_op_r == rcpwd_pkg::OP_READ);
    prod_nxt.product = (in_dz || !confirmed) ? 32'sd0 : product[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      prod_r.valid <= 1'b0;
      last_edge_r  <= '0;
      offset_r     <= '0;
      confirm_r    <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        prod_r.valid   <= prod_nxt.valid;
        prod_r.product <= prod_nxt.product;
      end
      last_edge_r <= last_edge_nxt;
      offset_r    <= offset_nxt;
      confirm_r   <= confirm_nxt;
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_op_r <= in_operation;
      s1_ts_r <= in_timestamp_us;
    end
  end

  a_confirm_step: assert property (@(posedge clk) disable iff (!rst_n)
    confirm_r != $past(confirm_r) |->
      (confirm_r == 2'd0 || confirm_r == $past(confirm_r) + 2'd1))
    else $error("confirmation counter jumped");

  a_edge_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_op_r == rcpwd_pkg::OP_EDGE) |=> !prod_r.valid)
    else $error("edge word produced a result");

  a_unconfirmed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_op_r == rcpwd_pkg::OP_READ && !confirmed) |=> prod_r.product == 32'sd0)
    else $error("unconfirmed read gave a non-zero product");

endmodule

/* hw/rtl/rcpwd_out_stage.sv */
// Halving, saturation and result register of the decoder.
module rcpwd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  rcpwd_pkg::prod_t  prod,
  output logic              prod_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [15:0] out_position
);

  logic               out_valid_r;
  logic signed [15:0] position_r;
  logic signed [15:0] position_nxt;
  logic signed [30:0] half;
  logic               load;

  assign prod_ready   = !out_valid_r || out_ready;
  assign load         = prod_ready && prod.valid;
  assign out_valid    = out_valid_r;
  assign out_position = position_r;

  // Drop the low bit: arithmetic shift floors towards minus infinity
  assign half = prod.product[31:1];

  always_comb begin
    priority if (half > 31'sd32767) begin
      position_nxt = 16'sh7fff;
    end else if (half < -31'sd32768) begin
      position_nxt = 16'sh8000;
    end else begin
      position_nxt = half[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (prod_ready) begin
      out_valid_r <= prod.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready) begin
      position_r <= position_nxt;
    end
  end

  a_sign_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !prod.product[31]) |=> !position_r[15])
    else $error("non-negative product gave a negative position");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(position_r)))
    else $error("result word changed while waiting");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("loaded product gave no result word");

endmodule

/* hw/rtl/rc_pulse_width_decoder_unit.sv */
// A read word reaches out_valid through the input, product and result registers.
// Throughput: one word per cycle; each register advances on its own ready, so a waiting
// result stalls new words only once input, product and result registers are all full.
// Edge words give no result. Reset (rst_n low, synchronous) clears the pulse state,
// the confirmation count and all valid bits, and loads the register defaults.
// Top level of the RC pulse width decoder.
module rc_pulse_width_decoder_unit #(
  parameter int TIMESTAMP_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [31:0]                       in_timestamp_us,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [15:0]                out_position,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rcpwd_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [rcpwd_pkg::CfgDataBits-1:0] cfg_data
);

  rcpwd_pkg::cfg_t  cfg;
  rcpwd_pkg::prod_t prod;
  logic             prod_ready;

  rcpwd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rcpwd_core #(
    .TIMESTAMP_BITS (TIMESTAMP_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_timestamp_us (in_timestamp_us),
    .cfg             (cfg),
    .prod            (prod),
    .prod_ready      (prod_ready)
  );

  rcpwd_out_stage u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .prod         (prod),
    .prod_ready   (prod_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_position (out_position)
  );

endmodule

/* tb/sv/rcpwd_position_monitor.sv */
// Position monitor: predicts the decoder's stick positions and checks every result word.
module rcpwd_position_monitor (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              in_operation,
  input  logic [31:0]                       in_timestamp_us,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [15:0]                out_position,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [rcpwd_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [rcpwd_pkg::CfgDataBits-1:0] cfg_data,
  output int                                errors,
  output int                                pending
);

  rcpwd_pkg::cfg_t    regs;
  logic [31:0]        last_edge_us;
  logic signed [15:0] pulse_off;
  logic [1:0]         confirm_cnt;
  logic signed [15:0] expected_position_q[$];

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  task automatic take_edge(input logic [31:0] ts);
    logic [31:0] gap;
    gap = ts - last_edge_us;
    // gaps beyond the limit are inter-pulse space: keep the old offset
    if (gap <= {16'd0, regs.gap_limit_us})
      pulse_off = clamp16(longint'(gap) - longint'(regs.median_us));
    last_edge_us = ts;
  endtask

  task automatic predict_position(output logic signed [15:0] pos);
    int     mag;
    int     dz;
    longint prod;
    dz  = int'(regs.deadzone_us);
    mag = (pulse_off < 0) ? -int'(pulse_off) : int'(pulse_off);
    pos = '0;
    if (mag < dz) begin
      confirm_cnt = '0;
    end else if (confirm_cnt == rcpwd_pkg::CONFIRM_DONE) begin
      if (pulse_off > 0)
        prod = longint'(int'(pulse_off) - dz) * longint'(regs.gain_pos);
      else
        prod = longint'(int'(pulse_off) + dz) * longint'(regs.gain_neg);
      // arithmetic shift floors towards minus infinity
      pos = clamp16(prod >>> 1);
    end else begin
      confirm_cnt = confirm_cnt + 2'd1;
    end
  endtask

  always @(posedge clk) begin : watch
    logic signed [15:0] want;
    if (!rst_n) begin
      regs.median_us    = rcpwd_pkg::MEDIAN_RST;
      regs.deadzone_us  = rcpwd_pkg::DEADZONE_RST;
      regs.gap_limit_us = rcpwd_pkg::GAP_LIM_RST;
      regs.gain_pos     = rcpwd_pkg::GAIN_RST;
      regs.gain_neg     = rcpwd_pkg::GAIN_RST;
      last_edge_us      = '0;
      pulse_off         = '0;
      confirm_cnt       = '0;
      expected_position_q.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      // check before predicting: a word accepted now cannot have its result yet
      if (out_valid && out_ready) begin
        if (expected_position_q.size() == 0) begin
          $error("position: no result expected, actual %0d", out_position);
          errors <= errors + 1;
        end else begin
          want = expected_position_q.pop_front();
          if (out_position !== want) begin
            $error("position: expected %0d, actual %0d", want, out_position);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rcpwd_pkg::CFG_MEDIAN:   regs.median_us    = cfg_data[11:0];
          rcpwd_pkg::CFG_DEADZONE: regs.deadzone_us  = cfg_data[9:0];
          rcpwd_pkg::CFG_GAP_LIM:  regs.gap_limit_us = cfg_data;
          rcpwd_pkg::CFG_GAIN_POS: regs.gain_pos     = cfg_data;
          rcpwd_pkg::CFG_GAIN_NEG: regs.gain_neg     = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_operation == rcpwd_pkg::OP_EDGE) begin
          take_edge(in_timestamp_us);
        end else begin
          predict_position(want);
          expected_position_q.push_back(want);
        end
      end
      pending <= expected_position_q.size();
    end
  end

endmodule

/* tb/sv/tb.sv */
// Top of the decoder testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb;

  localparam int WatchdogLimit = 2000;
  localparam int HoldOffCycles = 300;
  localparam int SettleCycles  = 6;
  localparam int PhaseItems    = 180;
  localparam int NumPhases     = 8;
  localparam int IdxBits       = rcpwd_pkg::CfgIdxBits;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic                              in_operation;
  logic [31:0]                       in_timestamp_us;
  logic                              out_valid;
  logic                              out_ready;
  logic signed [15:0]                out_position;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [rcpwd_pkg::CfgIdxBits-1:0]  cfg_index;
  logic [rcpwd_pkg::CfgDataBits-1:0] cfg_data;

  int          errors;
  int          pending;
  logic        hold_off_req = 1'b0;
  logic [31:0] now_us;
  logic [11:0] cur_median;
  logic [9:0]  cur_deadzone;
  logic [15:0] cur_gap_lim;
  int          sent_cnt;
  int          burst_left;

  rc_pulse_width_decoder_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_timestamp_us (in_timestamp_us),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_position    (out_position),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  rcpwd_position_monitor u_mon (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_timestamp_us (in_timestamp_us),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_position    (out_position),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .errors          (errors),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    int quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : receiver
    logic [15:0] pat;
    int          mode_left;
    logic        held;
    out_ready <= 1'b0;
    pat       = '1;
    mode_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(80, 20);
        case ($urandom_range(2, 0))
          0:       pat = '1;
          1:       pat = 16'($urandom);
          default: pat = 16'($urandom & $urandom);
        endcase
        pat[0] = 1'b1;
      end
      mode_left--;
      out_ready <= pat[0];
      pat = {pat[0], pat[15:1]};
    end
  end

  // Every task below is entered and left just after a rising edge.
  task automatic send_word(input logic op, input logic [31:0] ts);
    int idle;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      idle = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (idle != 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_timestamp_us <= ts;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
  endtask

  task automatic edge_at(input logic [31:0] ts);
    send_word(rcpwd_pkg::OP_EDGE, ts);
    now_us = ts;
  endtask

  task automatic read_pos();
    // timestamp field carries noise: it must be ignored on reads
    send_word(rcpwd_pkg::OP_READ, $urandom);
  endtask

  task automatic write_reg(input logic [rcpwd_pkg::CfgIdxBits-1:0]  idx,
                           input logic [rcpwd_pkg::CfgDataBits-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_all(input logic [15:0] median, input logic [15:0] deadzone,
                         input logic [15:0] gap_lim, input logic [15:0] gain_p,
                         input logic [15:0] gain_n);
    write_reg(rcpwd_pkg::CFG_MEDIAN, median);
    write_reg(rcpwd_pkg::CFG_DEADZONE, deadzone);
    write_reg(rcpwd_pkg::CFG_GAP_LIM, gap_lim);
    write_reg(rcpwd_pkg::CFG_GAIN_POS, gain_p);
    write_reg(rcpwd_pkg::CFG_GAIN_NEG, gain_n);
    cur_median   = median[11:0];
    cur_deadzone = deadzone[9:0];
    cur_gap_lim  = gap_lim;
  endtask

  // Drain results, then let edge words still in the pipe finish.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // One servo frame: space, pulse, then a few reads.
  task automatic send_frame();
    int kind;
    int width;
    int off;
    int nreads;
    kind = $urandom_range(19, 0);
    edge_at(now_us + 32'(cur_gap_lim) + $urandom_range(20000, 1));
    if (kind < 12) begin
      width = int'(cur_median) + int'($urandom_range(1400, 0)) - 700;
    end else if (kind < 15) begin
      // hover around the deadzone edge on either side
      off = int'(cur_deadzone) + int'($urandom_range(6, 0)) - 3;
      if ($urandom_range(1, 0) == 1) off = -off;
      width = int'(cur_median) + off;
    end else if (kind < 18) begin
      width = int'($urandom_range(cur_gap_lim, 0));
    end else begin
      width = int'(cur_gap_lim) + int'($urandom_range(3, 1));
    end
    if (width < 0) width = 0;
    edge_at(now_us + 32'(width));
    nreads = $urandom_range(5, 0);
    repeat (nreads) read_pos();
  endtask

  task automatic random_items(input int n);
    int stop_at;
    stop_at = sent_cnt + n;
    while (sent_cnt < stop_at) begin
      case ($urandom_range(9, 0))
        7:       edge_at($urandom);
        8:       read_pos();
        9:       edge_at(now_us + $urandom_range(200, 0));
        default: send_frame();
      endcase
    end
  endtask

  initial begin : stimulus
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_operation    <= rcpwd_pkg::OP_EDGE;
    in_timestamp_us <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= rcpwd_pkg::CFG_MEDIAN;
    cfg_data        <= '0;
    cur_median   = rcpwd_pkg::MEDIAN_RST;
    cur_deadzone = rcpwd_pkg::DEADZONE_RST;
    cur_gap_lim  = rcpwd_pkg::GAP_LIM_RST;
    now_us       = '0;
    sent_cnt     = 0;
    burst_left   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on the reset settings.
    read_pos();
    edge_at(32'd0);
    repeat (4) read_pos();
    edge_at(32'hFFFF_FFFF);
    edge_at(32'd2000);
    read_pos();
    edge_at(now_us + 32'd5000);
    edge_at(now_us + 32'd3000);
    read_pos();
    edge_at(now_us + 32'd3001);
    read_pos();
    edge_at(now_us + 32'd1510);
    repeat (2) read_pos();
    edge_at(now_us + 32'd1520);
    repeat (4) read_pos();
    edge_at(now_us + 32'd1480);
    read_pos();
    settle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: ;
        1: begin
          set_all(16'd4095, 16'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          // hold the receiver off while reads keep coming
          hold_off_req = 1'b1;
          repeat (40) read_pos();
        end
        2: begin
          set_all(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
          edge_at(now_us + 32'd70000);
          edge_at(now_us + 32'd65535);
          repeat (4) read_pos();
          edge_at(now_us);
          repeat (2) read_pos();
        end
        3: set_all(16'd0, 16'd0, 16'd0, 16'd1, 16'd1);
        NumPhases - 1:
          set_all(16'(rcpwd_pkg::MEDIAN_RST), 16'(rcpwd_pkg::DEADZONE_RST),
                  rcpwd_pkg::GAP_LIM_RST, rcpwd_pkg::GAIN_RST, rcpwd_pkg::GAIN_RST);
        default: begin
          write_reg(IdxBits'($urandom_range(7, int'(rcpwd_pkg::CFG_GAIN_NEG) + 1)),
                    16'($urandom));
          set_all(16'($urandom), 16'($urandom_range(100, 0)),
                  16'($urandom_range(65535, 500)), 16'($urandom), 16'($urandom));
        end
      endcase
      random_items(PhaseItems);
      settle();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rcpwd_pkg.sv
hw/rtl/rcpwd_cfg_regs.sv
hw/rtl/rcpwd_core.sv
hw/rtl/rcpwd_out_stage.sv
hw/rtl/rc_pulse_width_decoder_unit.sv
tb/sv/rcpwd_position_monitor.sv
tb/sv/tb.sv
